// ===== hw/rtl/llsa_pkg.sv =====
// ----------------------------------------------------------------------------
// llsa_pkg
// Shared sizes and status codes for the least-loaded slot assigner.
// ----------------------------------------------------------------------------
package llsa_pkg;
  localparam int NumWorkers = 16;
  localparam int SlotsPerWorker = 16;
  localparam int WW = 4;  // worker index bits
  localparam int SW = 4;  // slot index bits
  localparam int CW = 5;  // count width

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_PRESENT   = 3'd1;
  localparam logic [2:0] ST_REMOVED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_DROPPED   = 3'd4;

  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;
endpackage

// ===== hw/rtl/least_loaded_slot_assigner_top.sv =====
// ----------------------------------------------------------------------------
// least_loaded_slot_assigner_top
// Places client IDs into per-worker slot rows held in one row-wide memory.
// ----------------------------------------------------------------------------
// Flow: a zero ID skips the memory and goes straight to the output
//   register. Otherwise the match scan reads one memory row per cycle
//   through the registered read port. An add or remove that changes a row
//   then reads that row once and writes it back.
// Handshake: one word at a time. The next word can be taken in the cycle
//   after the result moves into the output register. A result that is still
//   waiting stalls the block.
// Reset: rst clears control, counts and opened count at once, then sweeps
//   the slot memory to zero one row per cycle while s_tready stays low.
module least_loaded_slot_assigner_top
  import llsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // client_id[63:0]
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // status[2:0], worker_index[6:3],
                                 // slot_index[10:7], zero[15:11]
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;  // match scan, one row per cycle
  localparam logic [2:0] S_RD   = 3'd3;  // read the target row
  localparam logic [2:0] S_WR   = 3'd4;  // modify and write back
  localparam logic [2:0] S_OUT  = 3'd5;

  typedef logic [63:0] row_t [SlotsPerWorker];

  // Slot memory: one row per worker, registered read.
  row_t mem [NumWorkers];
  row_t rdata;
  logic          mem_we;
  logic [WW-1:0] mem_wa, mem_ra;
  row_t          mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata <= mem[mem_ra];
  end

  logic [CW-1:0] counts [NumWorkers];
  logic [CW-1:0] hwm [NumWorkers];
  logic [CW-1:0] opened, limit;
  logic [2:0]    state;
  logic [WW:0]   ptr;       // issued row address, one wider to hold the end
  logic [WW:0]   chk;       // row whose data sits in rdata
  logic          chk_v;
  logic          kind;
  logic [63:0]   cid;
  logic [WW-1:0] tw;
  logic [SW-1:0] ts;
  logic [2:0]    st;
  logic          found;
  logic [15:0]   obuf;
  logic          ovalid;

  // Match search in the row on the read port.
  logic          hit;
  logic [SW-1:0] hit_s;
  logic          free_v;
  logic [SW-1:0] free_s;
  logic [CW-1:0] hw_new;
  row_t          row_mod;

  always_comb begin
    hit = 1'b0; hit_s = '0;
    for (int s = SlotsPerWorker - 1; s >= 0; s--) begin
      if (rdata[s] == cid && (kind == KIND_REMOVE ||
          (CW'(s) < hwm[chk[WW-1:0]] && chk < opened))) begin
        hit = 1'b1; hit_s = SW'(s);
      end
    end
    free_v = 1'b0; free_s = '0;
    for (int s = SlotsPerWorker - 1; s >= 0; s--) begin
      if (rdata[s] == 64'd0) begin
        free_v = 1'b1; free_s = SW'(s);
      end
    end
    row_mod = rdata;
    if (kind == KIND_REMOVE) row_mod[ts] = 64'd0;
    else row_mod[free_s] = cid;
    hw_new = CW'(1);
    for (int s = 0; s < SlotsPerWorker; s++)
      if (row_mod[s] != 64'd0) hw_new = CW'(s + 1);
  end

  // Load pick over counters: lowest count among opened, lowest index wins.
  // Also first idle opened worker. Small (16 x 5-bit), done once per word.
  logic          idle_v;
  logic [WW-1:0] idle_w;
  logic [WW-1:0] ll_w;
  always_comb begin
    idle_v = 1'b0; idle_w = '0; ll_w = '0;
    for (int w = NumWorkers - 1; w >= 0; w--)
      if (CW'(w) < opened && counts[w] == '0) begin
        idle_v = 1'b1; idle_w = WW'(w);
      end
    for (int w = 1; w < NumWorkers; w++)
      if (CW'(w) < opened && counts[w] < counts[ll_w]) ll_w = WW'(w);
  end

  logic [CW-1:0] eff_lim;
  assign eff_lim = (limit > CW'(NumWorkers)) ? CW'(NumWorkers) : limit;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = ovalid;
  assign m_tdata  = obuf;

  always_comb begin
    mem_we = 1'b0; mem_wa = tw; mem_wd = row_mod;
    mem_ra = ptr[WW-1:0];
    if (state == S_CLR) begin
      mem_we = 1'b1; mem_wa = ptr[WW-1:0];
      for (int s = 0; s < SlotsPerWorker; s++) mem_wd[s] = 64'd0;
    end else if (state == S_RD) begin
      mem_ra = tw;
    end else if (state == S_WR) begin
      // drop leaves the row untouched
      mem_we = (st == ST_REMOVED || (st == ST_ADDED && free_v)) && !found;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; ptr <= '0; chk_v <= 1'b0; ovalid <= 1'b0;
      opened <= '0; limit <= CW'(16);
      for (int w = 0; w < NumWorkers; w++) begin
        counts[w] <= '0; hwm[w] <= '0;
      end
    end else begin
      if (cfg_we) limit <= cfg_wdata;
      if (ovalid && m_tready && state != S_OUT) ovalid <= 1'b0;
      case (state)
        S_CLR: begin
          ptr <= ptr + 1'b1;
          if (ptr == (WW + 1)'(NumWorkers - 1)) begin
            state <= S_IDLE; ptr <= '0;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            kind <= s_tuser; cid <= s_tdata; found <= 1'b0;
            ptr <= '0; chk_v <= 1'b0;
            if (s_tdata == 64'd0) begin
              st <= (s_tuser == KIND_REMOVE) ? ST_NOT_FOUND : ST_DROPPED;
              tw <= '0; ts <= '0; state <= S_OUT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Issue next row while checking the one that came back.
          if (ptr != (WW + 1)'(NumWorkers)) ptr <= ptr + 1'b1;
          chk <= ptr; chk_v <= (ptr != (WW + 1)'(NumWorkers));
          if (chk_v && hit) begin
            tw <= chk[WW-1:0]; ts <= hit_s;
            if (kind == KIND_REMOVE) begin
              st <= ST_REMOVED; state <= S_RD;
            end else begin
              st <= ST_PRESENT; found <= 1'b1; state <= S_OUT;
            end
          end else if (chk_v && chk == (WW + 1)'(NumWorkers - 1)) begin
            ts <= '0;
            if (kind == KIND_REMOVE) begin
              st <= ST_NOT_FOUND; tw <= '0; state <= S_OUT;
            end else if (idle_v) begin
              st <= ST_ADDED; tw <= idle_w; state <= S_RD;
            end else if (opened < eff_lim) begin
              st <= ST_ADDED; tw <= opened[WW-1:0]; state <= S_RD;
              opened <= opened + 1'b1;
            end else if (opened == '0) begin
              st <= ST_DROPPED; tw <= '0; state <= S_OUT;
            end else begin
              st <= ST_ADDED; tw <= ll_w; state <= S_RD;
            end
          end
        end
        S_RD: state <= S_WR;
        S_WR: begin
          if (kind == KIND_REMOVE) begin
            if (counts[tw] != '0) counts[tw] <= counts[tw] - 1'b1;
          end else if (!free_v) begin
            st <= ST_DROPPED; tw <= '0; ts <= '0;
          end else begin
            ts <= free_s;
            counts[tw] <= counts[tw] + 1'b1;
            hwm[tw] <= hw_new;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!ovalid || m_tready) begin
            obuf <= {5'd0, ts, tw, st}; ovalid <= 1'b1; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result never waits in the output register while a word is taken
  // that would overwrite it without delivery.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && ovalid && !m_tready) |=> state == S_OUT)
    else $error("result overwritten");
  assert property (@(posedge clk) disable iff (rst)
    opened <= CW'(NumWorkers))
    else $error("opened count beyond worker count");
  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLR || state == S_WR))
    else $error("memory write outside clear or write-back");
endmodule

// ===== sim/tb_least_loaded_slot_assigner_top.sv =====
// ----------------------------------------------------------------------------
// tb_least_loaded_slot_assigner_top
// Self-checking bench: drives add/remove words with random gaps, predicts
// each status word from a behavioral copy of the slot tables, and compares
// every output word in order. Sweeps the worker limit across several values.
// ----------------------------------------------------------------------------
module tb_least_loaded_slot_assigner_top;
  import llsa_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [63:0] id;
  } req_t;

  typedef struct packed {
    logic [2:0]    status;
    logic [WW-1:0] worker;
    logic [SW-1:0] slot;
  } resp_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;

  least_loaded_slot_assigner_top DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  // Shadow copy of the block's tables
  logic [63:0] tbl_ids [NumWorkers][SlotsPerWorker];
  int unsigned tbl_cnt [NumWorkers];
  int unsigned tbl_hw  [NumWorkers];
  int unsigned opened;
  int unsigned limit_reg;

  req_t  pending_words[$];
  resp_t expected_words[$];
  int    errors;
  int    words_in;
  int    words_out;
  int    drive_gap;
  int    sink_gap;
  logic  drive_active;

  // Pool of IDs so that adds collide and removes hit
  logic [63:0] id_pool[32];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic resp_t mk(logic [2:0] st, int unsigned w, int unsigned s);
    resp_t r;
    r.status = st;
    r.worker = w[WW-1:0];
    r.slot   = s[SW-1:0];
    return r;
  endfunction

  function automatic resp_t place_client(logic [63:0] id);
    int unsigned best;
    int unsigned s;
    int unsigned h;
    if (id == 64'd0) return mk(ST_DROPPED, 0, 0);
    for (int unsigned w = 0; w < opened; w++)
      for (int unsigned k = 0; k < tbl_hw[w] && k < SlotsPerWorker; k++)
        if (tbl_ids[w][k] == id) return mk(ST_PRESENT, w, k);
    // reuse an idle opened worker
    for (int unsigned w = 0; w < opened; w++)
      if (tbl_cnt[w] == 0) begin
        tbl_ids[w][0] = id;
        tbl_cnt[w] = 1;
        tbl_hw[w] = 1;
        return mk(ST_ADDED, w, 0);
      end
    if (opened < limit_reg && opened < NumWorkers) begin
      tbl_ids[opened][0] = id;
      tbl_cnt[opened] = 1;
      tbl_hw[opened] = 1;
      opened++;
      return mk(ST_ADDED, opened - 1, 0);
    end
    if (opened == 0) return mk(ST_DROPPED, 0, 0);
    best = 0;
    for (int unsigned w = 1; w < opened; w++)
      if (tbl_cnt[w] < tbl_cnt[best]) best = w;
    s = SlotsPerWorker;
    for (int unsigned k = 0; k < SlotsPerWorker; k++)
      if (tbl_ids[best][k] == 64'd0 && s == SlotsPerWorker) s = k;
    if (s == SlotsPerWorker) return mk(ST_DROPPED, 0, 0);
    tbl_ids[best][s] = id;
    tbl_cnt[best]++;
    h = 1;
    for (int unsigned k = 0; k < SlotsPerWorker; k++)
      if (tbl_ids[best][k] != 64'd0) h = k + 1;
    tbl_hw[best] = h;
    return mk(ST_ADDED, best, s);
  endfunction

  function automatic resp_t evict_client(logic [63:0] id);
    if (id == 64'd0) return mk(ST_NOT_FOUND, 0, 0);
    for (int unsigned w = 0; w < NumWorkers; w++)
      for (int unsigned k = 0; k < SlotsPerWorker; k++)
        if (tbl_ids[w][k] == id) begin
          tbl_ids[w][k] = 64'd0;
          if (tbl_cnt[w] > 0) tbl_cnt[w]--;
          return mk(ST_REMOVED, w, k);
        end
    return mk(ST_NOT_FOUND, 0, 0);
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    $display("MISMATCH %s", msg);
  endtask

  // Driver: pop pending words, hold valid until accepted, then maybe pause
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      drive_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        // accepted: predict now, in acceptance order
        if (s_tuser == KIND_ADD) expected_words.push_back(place_client(s_tdata));
        else expected_words.push_back(evict_client(s_tdata));
        words_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (drive_gap > 0) begin
          s_tvalid <= 1'b0;
          drive_gap <= drive_gap - 1;
        end else if (drive_active && pending_words.size() > 0) begin
          req_t r;
          r = pending_words.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= r.kind;
          s_tdata <= r.id;
          drive_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each output word against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        resp_t got;
        got = {m_tdata[2:0], m_tdata[6:3], m_tdata[10:7]};
        words_out++;
        if (m_tdata[15:11] != 5'd0)
          report_mismatch($sformatf("nonzero pad bits %h", m_tdata));
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", m_tdata));
        end else begin
          resp_t want;
          want = expected_words.pop_front();
          if (got != want)
            report_mismatch($sformatf(
              "got st=%0d w=%0d s=%0d want st=%0d w=%0d s=%0d",
              got.status, got.worker, got.slot,
              want.status, want.worker, want.slot));
        end
      end
      // hold ready low for a random stretch, then raise it
      if (sink_gap > 0) begin
        m_tready <= 1'b0;
        sink_gap <= sink_gap - 1;
      end else begin
        m_tready <= 1'b1;
        if (m_tvalid && m_tready)
          sink_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      end
    end
  end

  function automatic logic [63:0] pick_id();
    case ($urandom_range(0, 9))
      0: return {$urandom, $urandom};
      1: return 64'd0;
      default: return id_pool[$urandom_range(0, 31)];
    endcase
  endfunction

  task automatic queue_word(logic kind, logic [63:0] id);
    req_t r;
    r.kind = kind;
    r.id = id;
    pending_words.push_back(r);
  endtask

  // Release queued words and wait until every result has come back
  task automatic run_phase();
    drive_active = 1'b1;
    @(negedge clk);
    while (pending_words.size() != 0 || s_tvalid || expected_words.size() != 0)
      @(negedge clk);
    drive_active = 1'b0;
    repeat (50) @(posedge clk);
  endtask

  task automatic set_limit(logic [4:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_reg = v;
  endtask

  initial begin
    logic [4:0] limits[6];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 5'd0;
    s_tvalid = 1'b0;
    s_tdata = 64'd0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    errors = 0;
    words_in = 0;
    words_out = 0;
    drive_active = 1'b0;
    opened = 0;
    limit_reg = 16;
    for (int w = 0; w < NumWorkers; w++) begin
      tbl_cnt[w] = 0;
      tbl_hw[w] = 0;
      for (int k = 0; k < SlotsPerWorker; k++) tbl_ids[w][k] = 64'd0;
    end
    for (int i = 0; i < 32; i++) id_pool[i] = {$urandom, $urandom} | 64'd1;
    id_pool[0] = 64'hFFFF_FFFF_FFFF_FFFF;
    id_pool[1] = 64'd1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset limit, zero IDs, extremes, duplicate, remove, miss
    queue_word(KIND_ADD, 64'd0);
    queue_word(KIND_REMOVE, 64'd0);
    queue_word(KIND_REMOVE, 64'd5);
    queue_word(KIND_ADD, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_word(KIND_ADD, 64'd1);
    queue_word(KIND_ADD, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_word(KIND_REMOVE, 64'd1);
    queue_word(KIND_ADD, 64'hAAAA_5555_AAAA_5555);
    queue_word(KIND_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_word(KIND_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF);
    run_phase();

    // Limit zero: no new worker opens; adds go to already opened workers only
    set_limit(5'd0);
    for (int i = 2; i < 8; i++) queue_word(KIND_ADD, 64'h5555_AAAA_5555_AAAA + i);
    run_phase();

    // Limit one: fill the opened workers past capacity to reach the drop case
    set_limit(5'd1);
    for (int i = 0; i < 40; i++) queue_word(KIND_ADD, 64'h1000 + i);
    run_phase();

    // Random phases over several limits, including the maximum register value
    limits = '{5'd2, 5'd16, 5'd31, 5'd4, 5'd1, 5'd0};
    foreach (limits[p]) begin
      set_limit(limits[p]);
      for (int i = 0; i < 250; i++) queue_word(1'($urandom_range(0, 1)), pick_id());
      run_phase();
    end

    $display("Covered %0d words in, %0d words out across worker limits 0..31.",
             words_in, words_out);
    if (errors == 0 && expected_words.size() == 0)
      $display("least_loaded_slot_assigner_top test passed");
    else
      $display("least_loaded_slot_assigner_top test failed");
    $finish;
  end

  initial begin
    #3000000;
    $display("least_loaded_slot_assigner_top test failed");
    $finish;
  end
endmodule
